@@ rtl/core/lpbp_pkg.sv @@
// ----------------------------------------------------------------------------
// lpbp_pkg
// Types and constants of the LED panel bit-plane packer: lightness curve
// constants, fixed-point reciprocals and the output pin positions.
// ----------------------------------------------------------------------------
package lpbp_pkg;

    localparam int LANES      = 6;
    localparam int LEVEL_BITS = 11;
    localparam int IDX_W      = 5;
    localparam int CH_W       = 8;
    localparam int BRT_W      = 7;
    localparam int V_W        = 15;
    localparam int T_W        = 16;
    localparam int SQ_W       = 32;
    localparam int CUBE_W     = 46;
    localparam int LO_N_W     = 27;
    localparam int LO_LVL_W   = 5;
    localparam int EST_W      = 13;
    localparam int NUM_W      = 60;
    localparam int MASK_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BRIGHTNESS   = 3'd0,
        CFG_SOLID_ENABLE = 3'd1,
        CFG_SOLID_RED    = 3'd2,
        CFG_SOLID_GREEN  = 3'd3,
        CFG_SOLID_BLUE   = 3'd4
    } t_cfg_idx;

    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX     = 11'd2047;
    localparam logic [BRT_W-1:0]      BRIGHTNESS_RST = 7'd100;
    localparam logic [V_W-1:0]        LOW_LIMIT     = 15'd2040;
    localparam logic [T_W-1:0]        T_OFFSET      = 16'd4080;

    // linear segment: level = floor((40940*v + 2300865) / 4601730)
    localparam logic [63:0] LO_DEN64 = 64'd4601730;
    localparam logic [15:0] LO_MUL   = 16'd40940;
    localparam logic [LO_N_W-1:0] LO_BIAS = 27'd2300865;
    localparam int          LO_SHIFT = 50;
    localparam logic [27:0] LO_RECIP =
        28'(((64'd1 << LO_SHIFT) + LO_DEN64 - 64'd1) / LO_DEN64);

    // cubic segment: level = floor((4094*t^3 + D) / (2*D)), D = 29580^3
    localparam logic [63:0] CUBE_DEN64 = 64'd29580 * 64'd29580 * 64'd29580;
    localparam logic [CUBE_W-1:0] CUBE_DEN  = CUBE_W'(CUBE_DEN64);
    localparam logic [CUBE_W-1:0] CUBE_DEN2 = CUBE_W'(CUBE_DEN64 << 1);
    localparam logic [11:0] HI_MUL   = 12'd4094;
    localparam int          HI_DROP  = 14;
    localparam int          HI_SHIFT = 37;
    localparam logic [17:0] HI_RECIP =
        18'((64'd2047 << (HI_DROP + HI_SHIFT)) / CUBE_DEN64);
    localparam logic [49:0] HI_ROUND = 50'd1 << (HI_SHIFT - 1);

    localparam logic [4:0] PIN_POS [LANES] = '{5'd5, 5'd13, 5'd6, 5'd12, 5'd16, 5'd23};
    localparam logic [MASK_W-1:0] PIN_ALLOWED = 24'h81_3060;

endpackage

@@ rtl/core/led_panel_bitplane_packer.sv @@
// ----------------------------------------------------------------------------
// led_panel_bitplane_packer
// Maps a column's upper and lower RGB pixels, or the solid color, through a
// CIE1931 lightness curve and packs one bit plane of the six levels into a panel pin word.
// ----------------------------------------------------------------------------
// Usage:
//   An item transfers at a rising edge with start high and busy low. The
//   six channels run in parallel lanes through a six-register pipeline:
//   brightness product, square and linear segment, cube, reciprocal
//   estimate, correction product, final compare and bit pick.
//   The result shows on o_pin_mask with o_valid high for one cycle. A new
//   item may transfer every cycle, so the throughput is one pixel pair per
//   clock; busy is low except during reset and until its register, set in
//   reset, has cleared.
//   The receiver cannot stall: each result is taken in its strobe cycle.
//   Configuration writes through i_cfg_we/i_cfg_idx/i_cfg_wdata take effect
//   once registered and must only be made while no item is in flight.
//   Reset clears the pipeline valids and loads brightness 100 and solid
//   mode off with a black solid color.
// ----------------------------------------------------------------------------
module led_panel_bitplane_packer #(
    parameter int PWM_PLANES = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_cfg_we,
    input  logic [lpbp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lpbp_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic [lpbp_pkg::CH_W-1:0]          i_top_red,
    input  logic [lpbp_pkg::CH_W-1:0]          i_top_green,
    input  logic [lpbp_pkg::CH_W-1:0]          i_top_blue,
    input  logic [lpbp_pkg::CH_W-1:0]          i_bottom_red,
    input  logic [lpbp_pkg::CH_W-1:0]          i_bottom_green,
    input  logic [lpbp_pkg::CH_W-1:0]          i_bottom_blue,
    input  logic [2:0]                         i_plane,
    output logic                               o_valid,
    output logic [lpbp_pkg::MASK_W-1:0]        o_pin_mask
);

    localparam int L = lpbp_pkg::LANES;
    localparam logic [lpbp_pkg::IDX_W-1:0] IDX_OFFSET =
        lpbp_pkg::IDX_W'(lpbp_pkg::LEVEL_BITS - PWM_PLANES);

    // configuration
    logic [lpbp_pkg::BRT_W-1:0] r_brightness;
    logic                       r_solid_en;
    logic [lpbp_pkg::CH_W-1:0]  r_solid_red, r_solid_green, r_solid_blue;

    logic r_busy;
    logic accept;

    // pipeline valids, one per stage
    logic [5:0] r_vld;

    logic [lpbp_pkg::IDX_W-1:0] r_idx [1:5];

    logic [lpbp_pkg::CH_W-1:0]     ch_sel   [L];
    logic [lpbp_pkg::V_W-1:0]      r_s1_v   [L];
    logic [lpbp_pkg::SQ_W-1:0]     r_s2_sq  [L];
    logic [lpbp_pkg::T_W-1:0]      r_s2_t   [L];
    logic [lpbp_pkg::LO_N_W-1:0]   r_s2_nlo [L];
    logic                          r_lo     [2:5][L];
    logic [lpbp_pkg::CUBE_W-1:0]   r_s3_c   [L];
    logic [lpbp_pkg::LO_LVL_W-1:0] r_llo    [3:5][L];
    logic [lpbp_pkg::EST_W-1:0]    r_est    [4:5][L];
    logic [lpbp_pkg::NUM_W-1:0]    r_num    [4:5][L];
    logic [lpbp_pkg::NUM_W-1:0]    r_s5_p   [L];

    logic [lpbp_pkg::MASK_W-1:0] n_mask;
    logic [lpbp_pkg::MASK_W-1:0] r_mask;

    assign busy   = r_busy | ~i_rst_n;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness  <= lpbp_pkg::BRIGHTNESS_RST;
            r_solid_en    <= 1'b0;
            r_solid_red   <= '0;
            r_solid_green <= '0;
            r_solid_blue  <= '0;
        end else if (i_cfg_we) begin
            unique case (lpbp_pkg::t_cfg_idx'(i_cfg_idx))
                lpbp_pkg::CFG_BRIGHTNESS:   r_brightness  <= i_cfg_wdata[lpbp_pkg::BRT_W-1:0];
                lpbp_pkg::CFG_SOLID_ENABLE: r_solid_en    <= i_cfg_wdata[0];
                lpbp_pkg::CFG_SOLID_RED:    r_solid_red   <= i_cfg_wdata;
                lpbp_pkg::CFG_SOLID_GREEN:  r_solid_green <= i_cfg_wdata;
                lpbp_pkg::CFG_SOLID_BLUE:   r_solid_blue  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_solid_en) begin
            ch_sel[0] = r_solid_red;
            ch_sel[1] = r_solid_green;
            ch_sel[2] = r_solid_blue;
            ch_sel[3] = r_solid_red;
            ch_sel[4] = r_solid_green;
            ch_sel[5] = r_solid_blue;
        end else begin
            ch_sel[0] = i_top_red;
            ch_sel[1] = i_top_green;
            ch_sel[2] = i_top_blue;
            ch_sel[3] = i_bottom_red;
            ch_sel[4] = i_bottom_green;
            ch_sel[5] = i_bottom_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], accept};
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        logic [lpbp_pkg::T_W-1:0] t;
        logic [54:0] lo_prod;
        logic [49:0] est_sum;

        r_idx[1] <= IDX_OFFSET + lpbp_pkg::IDX_W'(i_plane);
        for (int s = 2; s <= 5; s++) begin
            r_idx[s] <= r_idx[s-1];
        end

        for (int i = 0; i < L; i++) begin
            // stage 1: brightness product
            r_s1_v[i] <= lpbp_pkg::V_W'(ch_sel[i]) * lpbp_pkg::V_W'(r_brightness);

            // stage 2: cubic base squared, linear segment numerator
            t = lpbp_pkg::T_W'(r_s1_v[i]) + lpbp_pkg::T_OFFSET;
            r_s2_t[i]   <= t;
            r_s2_sq[i]  <= lpbp_pkg::SQ_W'(t) * lpbp_pkg::SQ_W'(t);
            r_lo[2][i]  <= (r_s1_v[i] <= lpbp_pkg::LOW_LIMIT);
            r_s2_nlo[i] <= lpbp_pkg::LO_N_W'(r_s1_v[i][10:0]) *
                           lpbp_pkg::LO_N_W'(lpbp_pkg::LO_MUL) + lpbp_pkg::LO_BIAS;

            // stage 3: cube, linear segment level by reciprocal
            r_s3_c[i]   <= lpbp_pkg::CUBE_W'(48'(r_s2_sq[i]) * 48'(r_s2_t[i]));
            lo_prod      = 55'(r_s2_nlo[i]) * 55'(lpbp_pkg::LO_RECIP);
            r_llo[3][i] <= lo_prod[54:lpbp_pkg::LO_SHIFT];
            r_lo[3][i]  <= r_lo[2][i];

            // stage 4: rounded quotient estimate, exact numerator
            est_sum = 50'(r_s3_c[i][lpbp_pkg::CUBE_W-1:lpbp_pkg::HI_DROP]) *
                      50'(lpbp_pkg::HI_RECIP) + lpbp_pkg::HI_ROUND;
            r_est[4][i] <= est_sum[49:lpbp_pkg::HI_SHIFT];
            r_num[4][i] <= lpbp_pkg::NUM_W'(r_s3_c[i]) * lpbp_pkg::NUM_W'(lpbp_pkg::HI_MUL) +
                           lpbp_pkg::NUM_W'(lpbp_pkg::CUBE_DEN);
            r_llo[4][i] <= r_llo[3][i];
            r_lo[4][i]  <= r_lo[3][i];

            // stage 5: divisor times next candidate
            r_s5_p[i]   <= lpbp_pkg::NUM_W'(lpbp_pkg::CUBE_DEN2) *
                           lpbp_pkg::NUM_W'(r_est[4][i] + lpbp_pkg::EST_W'(1));
            r_est[5][i] <= r_est[4][i];
            r_num[5][i] <= r_num[4][i];
            r_llo[5][i] <= r_llo[4][i];
            r_lo[5][i]  <= r_lo[4][i];
        end

        r_mask <= n_mask;
    end

    // stage 6: correct the estimate by one, select the linear or cubic level, clamp, pick the plane bit
    always_comb begin
        logic [lpbp_pkg::EST_W:0]        q;
        logic [lpbp_pkg::LEVEL_BITS-1:0] lvl;
        logic [15:0]                     lvl16;

        n_mask = '0;
        for (int i = 0; i < L; i++) begin
            if (r_num[5][i] >= r_s5_p[i]) begin
                q = (lpbp_pkg::EST_W+1)'(r_est[5][i]) + 14'd1;
            end else begin
                q = (lpbp_pkg::EST_W+1)'(r_est[5][i]);
            end
            if (r_lo[5][i]) begin
                lvl = lpbp_pkg::LEVEL_BITS'(r_llo[5][i]);
            end else if (q > (lpbp_pkg::EST_W+1)'(lpbp_pkg::LEVEL_MAX)) begin
                lvl = lpbp_pkg::LEVEL_MAX;
            end else begin
                lvl = q[lpbp_pkg::LEVEL_BITS-1:0];
            end
            lvl16 = 16'(lvl);
            n_mask[lpbp_pkg::PIN_POS[i]] =
                (r_idx[5] < lpbp_pkg::IDX_W'(lpbp_pkg::LEVEL_BITS)) & lvl16[r_idx[5][3:0]];
        end
    end

    assign o_valid    = r_vld[5];
    assign o_pin_mask = r_mask;

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##6 o_valid)
        else $error("result strobe missing six cycles after transfer");

    a_pins_only : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_pin_mask & ~lpbp_pkg::PIN_ALLOWED) == '0))
        else $error("pin word drives a bit outside the six color pins");

    a_no_busy : assert property (@(posedge i_clk)
        (i_rst_n && $past(i_rst_n)) |-> !busy)
        else $error("busy raised outside reset");

endmodule
